/* hw/rtl/label_text_escape_encoder_macros.svh */
// Assertion helpers shared by the encoder RTL.
`ifndef LABEL_TEXT_ESCAPE_ENCODER_MACROS_SVH
`define LABEL_TEXT_ESCAPE_ENCODER_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define LTE_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("invariant violated");

// Same-cycle implication.
`define LTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication violated");

// Next-cycle implication.
`define LTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* hw/rtl/lte_pkg.sv */
`default_nettype none

package lte_pkg;

    // Default depth of the request queue between classifier and emitter
    localparam int C_QUEUE_DEPTH = 2;

    // Longest escape sequence in bytes
    localparam int C_MAX_BYTES = 6;
    localparam int C_IDX_W     = $clog2(C_MAX_BYTES);

    // ASCII codes used in escapes
    localparam logic [6:0] C_BSLASH = 7'h5C;
    localparam logic [6:0] C_PIPE   = 7'h7C;
    localparam logic [6:0] C_AMP    = 7'h26;
    localparam logic [6:0] C_SEMI   = 7'h3B;
    localparam logic [6:0] C_CH_A   = 7'h61;
    localparam logic [6:0] C_CH_G   = 7'h67;
    localparam logic [6:0] C_CH_L   = 7'h6C;
    localparam logic [6:0] C_CH_M   = 7'h6D;
    localparam logic [6:0] C_CH_N   = 7'h6E;
    localparam logic [6:0] C_CH_O   = 7'h6F;
    localparam logic [6:0] C_CH_P   = 7'h70;
    localparam logic [6:0] C_CH_Q   = 7'h71;
    localparam logic [6:0] C_CH_T   = 7'h74;
    localparam logic [6:0] C_CH_U   = 7'h75;
    localparam logic [6:0] C_CH_X   = 7'h78;

    // Input code points that get special treatment
    localparam logic [15:0] C_CP_TAB   = 16'd9;
    localparam logic [15:0] C_CP_NL    = 16'd10;
    localparam logic [15:0] C_CP_SPACE = 16'd32;
    localparam logic [15:0] C_CP_DEL   = 16'd127;
    localparam logic [15:0] C_CP_PIPE  = 16'h007C;
    localparam logic [15:0] C_CP_AMP   = 16'h0026;
    localparam logic [15:0] C_CP_QUOT  = 16'h0022;
    localparam logic [15:0] C_CP_LT    = 16'h003C;
    localparam logic [15:0] C_CP_GT    = 16'h003E;

    // Escape class of one character
    typedef enum logic [3:0] {
        K_PIPE,
        K_AMP,
        K_QUOT,
        K_LT,
        K_GT,
        K_NL,
        K_TAB,
        K_PLAIN,
        K_HEX2,
        K_HEX4
    } t_kind;

    // One classified request held in the queue
    typedef struct packed {
        t_kind       kind;
        logic [15:0] code_unit;
        logic        end_of_text;
    } t_entry;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Lower-case hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = 7'h30 + {3'b000, nib};
        end else begin
            hex_char = 7'h57 + {3'b000, nib};
        end
    endfunction

    // Number of output bytes per class, minus one
    function automatic logic [C_IDX_W-1:0] kind_len_m1(input t_kind kind);
        unique case (kind)
            K_PIPE:  kind_len_m1 = C_IDX_W'(1);
            K_AMP:   kind_len_m1 = C_IDX_W'(4);
            K_QUOT:  kind_len_m1 = C_IDX_W'(5);
            K_LT:    kind_len_m1 = C_IDX_W'(3);
            K_GT:    kind_len_m1 = C_IDX_W'(3);
            K_NL:    kind_len_m1 = C_IDX_W'(1);
            K_TAB:   kind_len_m1 = C_IDX_W'(1);
            K_PLAIN: kind_len_m1 = C_IDX_W'(0);
            K_HEX2:  kind_len_m1 = C_IDX_W'(3);
            K_HEX4:  kind_len_m1 = C_IDX_W'(5);
            default: kind_len_m1 = C_IDX_W'(0);
        endcase
    endfunction

    // Byte at position idx of the escape for one character
    function automatic logic [6:0] escape_byte(input t_kind kind,
                                               input logic [15:0] cu,
                                               input logic [C_IDX_W-1:0] idx);
        logic [6:0] b;
        b = C_BSLASH;
        unique case (kind)
            K_PIPE: b = (idx == C_IDX_W'(0)) ? C_BSLASH : C_PIPE;
            K_NL:   b = (idx == C_IDX_W'(0)) ? C_BSLASH : C_CH_N;
            K_TAB:  b = (idx == C_IDX_W'(0)) ? C_BSLASH : C_CH_T;
            K_PLAIN: b = cu[6:0];
            K_AMP: begin
                case (idx)
                    C_IDX_W'(0): b = C_AMP;
                    C_IDX_W'(1): b = C_CH_A;
                    C_IDX_W'(2): b = C_CH_M;
                    C_IDX_W'(3): b = C_CH_P;
                    default:     b = C_SEMI;
                endcase
            end
            K_QUOT: begin
                case (idx)
                    C_IDX_W'(0): b = C_AMP;
                    C_IDX_W'(1): b = C_CH_Q;
                    C_IDX_W'(2): b = C_CH_U;
                    C_IDX_W'(3): b = C_CH_O;
                    C_IDX_W'(4): b = C_CH_T;
                    default:     b = C_SEMI;
                endcase
            end
            K_LT, K_GT: begin
                case (idx)
                    C_IDX_W'(0): b = C_AMP;
                    C_IDX_W'(1): b = (kind == K_LT) ? C_CH_L : C_CH_G;
                    C_IDX_W'(2): b = C_CH_T;
                    default:     b = C_SEMI;
                endcase
            end
            K_HEX2: begin
                case (idx)
                    C_IDX_W'(0): b = C_BSLASH;
                    C_IDX_W'(1): b = C_CH_X;
                    C_IDX_W'(2): b = hex_char(cu[7:4]);
                    default:     b = hex_char(cu[3:0]);
                endcase
            end
            K_HEX4: begin
                case (idx)
                    C_IDX_W'(0): b = C_BSLASH;
                    C_IDX_W'(1): b = C_CH_U;
                    C_IDX_W'(2): b = hex_char(cu[15:12]);
                    C_IDX_W'(3): b = hex_char(cu[11:8]);
                    C_IDX_W'(4): b = hex_char(cu[7:4]);
                    default:     b = hex_char(cu[3:0]);
                endcase
            end
            default: b = C_BSLASH;
        endcase
        escape_byte = b;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lte_if.sv */
`default_nettype none

// Character request channel
interface lte_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

// Escaped byte channel
interface lte_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_byte;
    logic       last_of_char;
    logic       last_of_text;

    modport source (output valid, output out_byte, output last_of_char,
                    output last_of_text, input ready);
    modport sink   (input valid, input out_byte, input last_of_char,
                    input last_of_text, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lte_classify.sv */
`default_nettype none

module lte_classify
    import lte_pkg::*;
(
    lte_in_if.sink   i_in,
    input  t_q_stat  i_stat,
    output logic     o_push,
    output t_entry   o_entry
);

    // Accept whenever the queue has room
    assign i_in.ready = !i_stat.full;
    assign o_push     = i_in.valid && !i_stat.full;

    // Escape class, first match wins
    always_comb begin
        priority if (i_in.code_unit == C_CP_PIPE) begin
            o_entry.kind = K_PIPE;
        end else if (i_in.code_unit == C_CP_AMP) begin
            o_entry.kind = K_AMP;
        end else if (i_in.code_unit == C_CP_QUOT) begin
            o_entry.kind = K_QUOT;
        end else if (i_in.code_unit == C_CP_LT) begin
            o_entry.kind = K_LT;
        end else if (i_in.code_unit == C_CP_GT) begin
            o_entry.kind = K_GT;
        end else if (i_in.code_unit == C_CP_NL) begin
            o_entry.kind = K_NL;
        end else if (i_in.code_unit == C_CP_TAB) begin
            o_entry.kind = K_TAB;
        end else if (i_in.code_unit >= C_CP_SPACE && i_in.code_unit < C_CP_DEL) begin
            o_entry.kind = K_PLAIN;
        end else if (i_in.code_unit[15:8] == 8'h00) begin
            o_entry.kind = K_HEX2;
        end else begin
            o_entry.kind = K_HEX4;
        end
        o_entry.code_unit   = i_in.code_unit;
        o_entry.end_of_text = i_in.end_of_text;
    end

endmodule

`default_nettype wire

/* hw/rtl/lte_queue.sv */
`default_nettype none

module lte_queue
    import lte_pkg::*;
#(
    parameter int P_DEPTH = C_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_q_stat o_stat
);

`include "label_text_escape_encoder_macros.svh"

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_entry             r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_stat.full  = (r_count == CNT_W'(P_DEPTH));
    assign o_stat.empty = (r_count == CNT_W'(0));
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `LTE_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(P_DEPTH))
    `LTE_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_stat.full)
    `LTE_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_stat.empty)

endmodule

`default_nettype wire

/* hw/rtl/lte_emit.sv */
`default_nettype none

module lte_emit
    import lte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  t_q_stat   i_stat,
    output logic      o_pop,
    lte_out_if.source o_out
);

`include "label_text_escape_encoder_macros.svh"

    logic [C_IDX_W-1:0] r_idx, n_idx;
    logic               r_valid, n_valid;
    logic [6:0]         r_byte;
    logic               r_last_char;
    logic               r_last_text;
    logic               w_load;
    logic               w_last;

    // Output register takes a byte from a non-empty queue when empty or being drained
    assign w_load = !i_stat.empty && (!r_valid || o_out.ready);
    assign w_last = (r_idx == kind_len_m1(i_head.kind));
    assign o_pop  = w_load && w_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
            n_idx   = w_last ? '0 : r_idx + C_IDX_W'(1);
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte      <= escape_byte(i_head.kind, i_head.code_unit, r_idx);
            r_last_char <= w_last;
            r_last_text <= w_last && i_head.end_of_text;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_byte;
    assign o_out.last_of_char = r_last_char;
    assign o_out.last_of_text = r_last_text;

    `LTE_ASSERT_ALWAYS(a_idx_bound, i_clk, i_rst_n, r_idx <= C_IDX_W'(C_MAX_BYTES - 1))
    `LTE_ASSERT_NEXT(a_pop_marks_last, i_clk, i_rst_n, o_pop, r_valid && r_last_char)
    `LTE_ASSERT_IMPL(a_text_needs_char, i_clk, i_rst_n, r_valid && r_last_text, r_last_char)

endmodule

`default_nettype wire

/* hw/rtl/label_text_escape_encoder.sv */
`default_nettype none
// Channel | Dir | Payload                                 | Handshake
// i_in    | in  | code_unit[15:0], end_of_text            | valid/ready
// o_out   | out | out_byte[6:0], last_of_char, last_of_text | valid/ready
//
// Each character yields 1 to 6 bytes, one byte per cycle while o_out is
// ready; the byte count of the escape class (up to 6 for &quot; and \uXXXX)
// sets the rate. The first byte passes the queue, then the output register.
// i_in takes a request every cycle while the request queue has room.
// Synchronous active-low reset empties the queue and the output register.
// A stall on o_out holds the byte; i_in keeps filling the queue meanwhile.

module label_text_escape_encoder
    import lte_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lte_in_if.sink    i_in,
    lte_out_if.source o_out
);

    t_q_stat w_stat;
    t_entry  w_push_entry;
    t_entry  w_head;
    logic    w_push;
    logic    w_pop;

    // Front: accept and classify
    lte_classify u_classify (
        .i_in    (i_in),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // Request queue
    lte_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // Back: byte sequencer
    lte_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
